// ----- rtl/mefb_pkg.sv -----
// shared constants for the motor encoder feedback tracker
// no dependencies; imported by every module of the block
package mefb_pkg;

  localparam int TICKS_LOG2_DEF = 13;
  localparam int TURN_BITS_DEF  = 32;

  localparam int SPEED_W = 16;
  localparam int CURR_W  = 16;
  localparam int TEMP_W  = 8;
  localparam int TURN_W  = 32;
  localparam int POS_W   = 45;
  localparam int POWER_W = 22;
  localparam int SETTLE_W = 8;
  localparam int COEFF_W = 24;
  localparam int CNT_W   = 9;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_COEFF  = 1'b1;

  localparam logic [SETTLE_W-1:0] SETTLE_COUNT_RST = 8'd50;
  localparam logic [COEFF_W-1:0]  POWER_COEFF_RST  = 24'd4332603;

  localparam int FIFO_DEPTH = 2;

  // handshake between the queue and its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } mefb_q_status_t;

endpackage

// ----- rtl/motor_encoder_feedback_tracker.sv -----
// top level of the motor encoder feedback tracker: config registers and wiring
// depends on mefb_pkg, mefb_front, mefb_fifo, mefb_back
//
//  channel  | handshake            | payload
//  in_      | in_valid / in_ready  | encoder_angle, rotor_speed, torque_current, temperature
//  out_     | out_valid/out_ready  | tracking, angle_now .. position_ticks, power_estimate
//  cfg_     | cfg_we               | cfg_index (0 settle_count, 1 power_coeff), cfg_wdata
//
//  in the back end an item goes through queue pop with turn scaling and
//  current*speed product, coefficient product, then the result register
//  until taken; the back-end sequence sets the sustained rate
//  a two-entry queue lets the front end keep accepting while a result stalls
//  reset (synchronous, rst_n low) clears calibration, turn count and queue
module motor_encoder_feedback_tracker #(
  parameter int TICKS_LOG2 = mefb_pkg::TICKS_LOG2_DEF,
  parameter int TURN_BITS  = mefb_pkg::TURN_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mefb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mefb_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [TICKS_LOG2-1:0]                in_encoder_angle,
  input  logic signed [mefb_pkg::SPEED_W-1:0]  in_rotor_speed,
  input  logic signed [mefb_pkg::CURR_W-1:0]   in_torque_current,
  input  logic [mefb_pkg::TEMP_W-1:0]          in_temperature,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_tracking,
  output logic [TICKS_LOG2-1:0]                out_angle_now,
  output logic signed [mefb_pkg::SPEED_W-1:0]  out_speed_out,
  output logic signed [mefb_pkg::CURR_W-1:0]   out_current_out,
  output logic [mefb_pkg::TEMP_W-1:0]          out_temperature_out,
  output logic signed [mefb_pkg::TURN_W-1:0]   out_turn_count,
  output logic signed [mefb_pkg::POS_W-1:0]    out_absolute_angle,
  output logic signed [mefb_pkg::POS_W-1:0]    out_position_ticks,
  output logic [mefb_pkg::POWER_W-1:0]         out_power_estimate
);
  import mefb_pkg::*;

  localparam int ENTRY_W = 41 + 2 * TICKS_LOG2 + TURN_BITS;

  logic [SETTLE_W-1:0] settle_count_r;
  logic [COEFF_W-1:0]  power_coeff_r;

  mefb_q_status_t      q_status;
  logic                q_push, q_pop;
  logic [ENTRY_W-1:0]  q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_count_r <= SETTLE_COUNT_RST;
      power_coeff_r  <= POWER_COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE_COUNT: settle_count_r <= cfg_wdata[SETTLE_W-1:0];
        CFG_POWER_COEFF:  power_coeff_r  <= cfg_wdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  mefb_front #(
    .TICKS_LOG2 (TICKS_LOG2),
    .TURN_BITS  (TURN_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_encoder_angle  (in_encoder_angle),
    .in_rotor_speed    (in_rotor_speed),
    .in_torque_current (in_torque_current),
    .in_temperature    (in_temperature),
    .settle_count      (settle_count_r),
    .q_status          (q_status),
    .q_push            (q_push),
    .q_entry           (q_in)
  );

  mefb_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  mefb_back #(
    .TICKS_LOG2 (TICKS_LOG2),
    .TURN_BITS  (TURN_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_status            (q_status),
    .q_entry             (q_out),
    .q_pop               (q_pop),
    .power_coeff         (power_coeff_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tracking        (out_tracking),
    .out_angle_now       (out_angle_now),
    .out_speed_out       (out_speed_out),
    .out_current_out     (out_current_out),
    .out_temperature_out (out_temperature_out),
    .out_turn_count      (out_turn_count),
    .out_absolute_angle  (out_absolute_angle),
    .out_position_ticks  (out_position_ticks),
    .out_power_estimate  (out_power_estimate)
  );

endmodule

// ----- rtl/mefb_front.sv -----
// front end: takes feedback frames, runs offset capture and turn unwrap
// depends on mefb_pkg; pushes one packed entry per frame into mefb_fifo
module mefb_front #(
  parameter int TICKS_LOG2 = mefb_pkg::TICKS_LOG2_DEF,
  parameter int TURN_BITS  = mefb_pkg::TURN_BITS_DEF,
  parameter int ENTRY_W    = 41 + 2 * TICKS_LOG2 + TURN_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [TICKS_LOG2-1:0]               in_encoder_angle,
  input  logic signed [mefb_pkg::SPEED_W-1:0] in_rotor_speed,
  input  logic signed [mefb_pkg::CURR_W-1:0]  in_torque_current,
  input  logic [mefb_pkg::TEMP_W-1:0]         in_temperature,
  input  logic [mefb_pkg::SETTLE_W-1:0]       settle_count,
  input  mefb_pkg::mefb_q_status_t            q_status,
  output logic                                q_push,
  output logic [ENTRY_W-1:0]                  q_entry
);
  import mefb_pkg::*;

  localparam logic signed [TICKS_LOG2+1:0] HALF  = (TICKS_LOG2+2)'(1) << (TICKS_LOG2 - 1);
  localparam logic signed [TICKS_LOG2+1:0] NHALF = -HALF;

  logic                  ready_r, ready_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TICKS_LOG2-1:0] offset_r, offset_nxt;
  logic [TICKS_LOG2-1:0] prev_r, prev_nxt;
  logic [TURN_BITS-1:0]  turns_r, turns_nxt;
  logic signed [TICKS_LOG2+1:0] diff;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && !q_status.full;
  assign diff     = $signed({2'b00, in_encoder_angle}) - $signed({2'b00, prev_r});

  always_comb begin
    ready_nxt  = ready_r;
    cnt_nxt    = cnt_r;
    offset_nxt = offset_r;
    prev_nxt   = prev_r;
    turns_nxt  = turns_r;
    if (q_push) begin
      if (!ready_r) begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt > {1'b0, settle_count}) begin
          ready_nxt = 1'b1;
        end else begin
          offset_nxt = in_encoder_angle;
        end
        prev_nxt = offset_nxt;
      end else begin
        // a jump of more than half a turn is a wrap
        if (diff > HALF) begin
          turns_nxt = turns_r - 1'b1;
        end else if (diff < NHALF) begin
          turns_nxt = turns_r + 1'b1;
        end
        prev_nxt = in_encoder_angle;
      end
    end
  end

  assign q_entry = {ready_r, in_encoder_angle, in_rotor_speed, in_torque_current,
                    in_temperature, turns_nxt, offset_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= 1'b0;
      cnt_r    <= '0;
      offset_r <= '0;
      prev_r   <= '0;
      turns_r  <= '0;
    end else begin
      ready_r  <= ready_nxt;
      cnt_r    <= cnt_nxt;
      offset_r <= offset_nxt;
      prev_r   <= prev_nxt;
      turns_r  <= turns_nxt;
    end
  end

  // once calibrated the tracker never falls back to capture
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |=> ready_r)
    else $error("ready flag dropped after calibration");

endmodule

// ----- rtl/mefb_fifo.sv -----
// short queue between the front end and the back end
// depends on mefb_pkg for depth and status type
module mefb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         pop_data,
  output mefb_pkg::mefb_q_status_t status
);
  import mefb_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_QW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0]  mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign status.full  = (count_r == CNT_QW'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_QW'(push) - CNT_QW'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full) && !(pop && status.empty))
    else $error("queue pushed while full or popped while empty");

endmodule

// ----- rtl/mefb_back.sv -----
// back end: position arithmetic, power estimate and the result register
// depends on mefb_pkg; pops packed entries from mefb_fifo
module mefb_back #(
  parameter int TICKS_LOG2 = mefb_pkg::TICKS_LOG2_DEF,
  parameter int TURN_BITS  = mefb_pkg::TURN_BITS_DEF,
  parameter int ENTRY_W    = 41 + 2 * TICKS_LOG2 + TURN_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mefb_pkg::mefb_q_status_t             q_status,
  input  logic [ENTRY_W-1:0]                   q_entry,
  output logic                                 q_pop,
  input  logic [mefb_pkg::COEFF_W-1:0]         power_coeff,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_tracking,
  output logic [TICKS_LOG2-1:0]                out_angle_now,
  output logic signed [mefb_pkg::SPEED_W-1:0]  out_speed_out,
  output logic signed [mefb_pkg::CURR_W-1:0]   out_current_out,
  output logic [mefb_pkg::TEMP_W-1:0]          out_temperature_out,
  output logic signed [mefb_pkg::TURN_W-1:0]   out_turn_count,
  output logic signed [mefb_pkg::POS_W-1:0]    out_absolute_angle,
  output logic signed [mefb_pkg::POS_W-1:0]    out_position_ticks,
  output logic [mefb_pkg::POWER_W-1:0]         out_power_estimate
);
  import mefb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam int PMUL_W = 31 + COEFF_W;

  logic [1:0] state_r, state_nxt;

  // unpacked entry fields
  logic                         e_tracking;
  logic [TICKS_LOG2-1:0]        e_angle;
  logic signed [SPEED_W-1:0]    e_speed;
  logic signed [CURR_W-1:0]     e_current;
  logic [TEMP_W-1:0]            e_temp;
  logic [TURN_BITS-1:0]         e_turns;
  logic [TICKS_LOG2-1:0]        e_offset;

  // working registers
  logic                         trk_r;
  logic [TICKS_LOG2-1:0]        angle_r;
  logic signed [SPEED_W-1:0]    speed_r;
  logic signed [CURR_W-1:0]     current_r;
  logic [TEMP_W-1:0]            temp_r;
  logic signed [TURN_W-1:0]     turns_r;
  logic [TICKS_LOG2-1:0]        offset_r;
  logic signed [31:0]           prod_r;
  logic [POS_W-1:0]             abs_r;

  logic signed [63:0]           turns64;
  logic [63:0]                  abs64;
  logic [PMUL_W-1:0]            pmul;
  logic [POWER_W-1:0]           power;

  logic                         ov_r;

  assign {e_tracking, e_angle, e_speed, e_current, e_temp, e_turns, e_offset} = q_entry;

  assign q_pop   = (state_r == ST_IDLE) && !q_status.empty;
  assign turns64 = 64'($signed(e_turns));
  assign abs64   = 64'(turns64 <<< TICKS_LOG2) + 64'(e_angle);
  assign pmul    = PMUL_W'(prod_r[30:0]) * PMUL_W'(power_coeff);
  // product of zero or less gives no power
  assign power   = (prod_r > 0) ? pmul[32 +: POWER_W] : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_nxt == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      trk_r     <= e_tracking;
      angle_r   <= e_angle;
      speed_r   <= e_speed;
      current_r <= e_current;
      temp_r    <= e_temp;
      turns_r   <= TURN_W'($signed(e_turns));
      offset_r  <= e_offset;
      prod_r    <= 32'(e_current) * 32'(e_speed);
      abs_r     <= abs64[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      out_tracking        <= trk_r;
      out_angle_now       <= trk_r ? angle_r : '0;
      out_speed_out       <= trk_r ? speed_r : '0;
      out_current_out     <= trk_r ? current_r : '0;
      out_temperature_out <= trk_r ? temp_r : '0;
      out_turn_count      <= trk_r ? turns_r : '0;
      out_absolute_angle  <= trk_r ? abs_r : '0;
      out_position_ticks  <= trk_r ? (abs_r - POS_W'(offset_r)) : '0;
      out_power_estimate  <= trk_r ? power : '0;
    end
  end

  assign out_valid = ov_r;

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == (state_r == ST_OUT))
    else $error("result valid out of step with sequencer");

  a_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tracking) |-> (out_position_ticks == '0 && out_power_estimate == '0))
    else $error("capture frame result not cleared");

  a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_absolute_angle)))
    else $error("stalled result changed");

endmodule

// ----- tb/motor_encoder_feedback_tracker_test.sv -----
// self-checking testbench for motor_encoder_feedback_tracker: directed table, then random frames
// depends on mefb_pkg and the motor_encoder_feedback_tracker rtl; predicts results itself except for fixed table rows
module motor_encoder_feedback_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mefb_pkg::*;

  localparam int ANGLE_W     = TICKS_LOG2_DEF;
  localparam int HALF_TURN   = 1 << (ANGLE_W - 1);
  localparam int POWER_MAX   = 4194303;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 228;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic signed [SPEED_W-1:0] speed;
    logic signed [CURR_W-1:0]  current;
    logic [TEMP_W-1:0]         temp;
  } feedback_frame_t;

  typedef struct packed {
    logic                      tracking;
    logic [ANGLE_W-1:0]        angle;
    logic signed [SPEED_W-1:0] speed;
    logic signed [CURR_W-1:0]  current;
    logic [TEMP_W-1:0]         temp;
    logic signed [TURN_W-1:0]  turns;
    logic signed [POS_W-1:0]   abs_angle;
    logic signed [POS_W-1:0]   position;
    logic [POWER_W-1:0]        power;
  } track_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    feedback_frame_t      frame;
    bit                   fixed;
    track_result_t        res;
  } step_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic [ANGLE_W-1:0]        in_encoder_angle;
  logic signed [SPEED_W-1:0] in_rotor_speed;
  logic signed [CURR_W-1:0]  in_torque_current;
  logic [TEMP_W-1:0]         in_temperature;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_tracking;
  logic [ANGLE_W-1:0]        out_angle_now;
  logic signed [SPEED_W-1:0] out_speed_out;
  logic signed [CURR_W-1:0]  out_current_out;
  logic [TEMP_W-1:0]         out_temperature_out;
  logic signed [TURN_W-1:0]  out_turn_count;
  logic signed [POS_W-1:0]   out_absolute_angle;
  logic signed [POS_W-1:0]   out_position_ticks;
  logic [POWER_W-1:0]        out_power_estimate;

  motor_encoder_feedback_tracker u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_encoder_angle    (in_encoder_angle),
    .in_rotor_speed      (in_rotor_speed),
    .in_torque_current   (in_torque_current),
    .in_temperature      (in_temperature),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tracking        (out_tracking),
    .out_angle_now       (out_angle_now),
    .out_speed_out       (out_speed_out),
    .out_current_out     (out_current_out),
    .out_temperature_out (out_temperature_out),
    .out_turn_count      (out_turn_count),
    .out_absolute_angle  (out_absolute_angle),
    .out_position_ticks  (out_position_ticks),
    .out_power_estimate  (out_power_estimate)
  );

  // predictor state and register copies
  logic                 calibrated      = 1'b0;
  logic [CNT_W-1:0]     frames_seen     = '0;
  logic [ANGLE_W-1:0]   zero_angle      = '0;
  logic [ANGLE_W-1:0]   prev_seen_angle = '0;
  logic [TURN_W-1:0]    turn_total      = '0;
  logic [SETTLE_W-1:0]  settle_limit    = SETTLE_COUNT_RST;
  logic [COEFF_W-1:0]   power_scale     = POWER_COEFF_RST;

  track_result_t   pending_results[$];
  step_row_t       steps[$];
  logic [ANGLE_W-1:0] sent_angle = '0;
  bit              spin_down    = 1'b0;
  bit              hold_req     = 1'b0;
  int              mismatches   = 0;
  int              cycles       = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic track_result_t unwrap_frame(input feedback_frame_t f);
    track_result_t r;
    int delta;
    int prod;
    logic [63:0] scaled;
    r = '0;
    if (!calibrated) begin
      frames_seen = frames_seen + 1'b1;
      if (frames_seen > settle_limit) calibrated = 1'b1;
      else zero_angle = f.angle;
      prev_seen_angle = zero_angle;
      return r;
    end
    delta = int'(f.angle) - int'(prev_seen_angle);
    if (delta > HALF_TURN) turn_total = turn_total - 1'b1;
    else if (delta < -HALF_TURN) turn_total = turn_total + 1'b1;
    prev_seen_angle = f.angle;
    r.tracking  = 1'b1;
    r.angle     = f.angle;
    r.speed     = f.speed;
    r.current   = f.current;
    r.temp      = f.temp;
    r.turns     = turn_total;
    r.abs_angle = {turn_total, f.angle};
    r.position  = r.abs_angle - {{(POS_W-ANGLE_W){1'b0}}, zero_angle};
    prod = int'(f.current) * int'(f.speed);
    if (prod > 0) begin
      scaled = 64'(prod) * 64'(power_scale);
      r.power = (scaled[63:32] > POWER_MAX) ? POWER_W'(POWER_MAX) : scaled[53:32];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] rand_s16();
    logic signed [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = -16'sd1;
          2: v = 16'sd0;
          3: v = 16'sd1;
          default: v = 16'sh7fff;
        endcase
      end
      2: v = 16'(int'($urandom_range(0, 4000)) - 2000);
      default: v = 16'($urandom_range(0, 32767));
    endcase
    return v;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    step_row_t s;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.frame   = '0;
    s.fixed   = 1'b0;
    s.res     = '0;
    steps.push_back(s);
  endfunction

  function automatic void add_frame(input int angle, input int speed, input int current,
                                    input int temp, input bit fixed, input track_result_t res);
    step_row_t s;
    s.is_cfg        = 1'b0;
    s.reg_idx       = '0;
    s.reg_val       = '0;
    s.frame.angle   = ANGLE_W'(angle);
    s.frame.speed   = SPEED_W'(speed);
    s.frame.current = CURR_W'(current);
    s.frame.temp    = TEMP_W'(temp);
    s.fixed         = fixed;
    s.res           = res;
    steps.push_back(s);
  endfunction

  // waits for the block to drain, then writes one register
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SETTLE_COUNT) settle_limit = val[SETTLE_W-1:0];
    else if (idx == CFG_POWER_COEFF) power_scale = val[COEFF_W-1:0];
  endtask

  task automatic send_frame(input feedback_frame_t f, input bit fixed,
                            input track_result_t fixed_res);
    track_result_t r;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_encoder_angle  <= f.angle;
    in_rotor_speed    <= f.speed;
    in_torque_current <= f.current;
    in_temperature    <= f.temp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = unwrap_frame(f);
    pending_results.push_back(fixed ? fixed_res : r);
    sent_angle = f.angle;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  track_result_t want_res;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("result transaction with nothing expected");
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("tracking", 64'(want_res.tracking), 64'(out_tracking));
        check_field("angle_now", 64'(want_res.angle), 64'(out_angle_now));
        check_field("speed_out", 64'(want_res.speed), 64'(out_speed_out));
        check_field("current_out", 64'(want_res.current), 64'(out_current_out));
        check_field("temperature_out", 64'(want_res.temp), 64'(out_temperature_out));
        check_field("turn_count", 64'(want_res.turns), 64'(out_turn_count));
        check_field("absolute_angle", 64'(want_res.abs_angle), 64'(out_absolute_angle));
        check_field("position_ticks", 64'(want_res.position), 64'(out_position_ticks));
        check_field("power_estimate", 64'(want_res.power), 64'(out_power_estimate));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: segments of differing stall density, plus one long hold-off on request
  initial begin
    int seg_len;
    int seg_mode;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      seg_len  = $urandom_range(16, 160);
      seg_mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (seg_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 4) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    feedback_frame_t f;
    track_result_t peak;
    int ph;
    int sent;
    int burst;
    int gap;
    int step;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_encoder_angle  = '0;
    in_rotor_speed    = '0;
    in_torque_current = '0;
    in_temperature    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    peak = '{tracking: 1'b1, angle: 13'd4000, speed: 16'sh8000, current: 16'sh8000,
             temp: 8'd70, turns: '0, abs_angle: 45'd4000, position: '0,
             power: 22'h3fffff};

    add_cfg(CFG_SETTLE_COUNT, 24'd4);
    add_cfg(CFG_POWER_COEFF, 24'hffffff);
    // offset capture frames report all zeros
    add_frame(8191, 32767, 32767, 255, 1'b1, '0);
    add_frame(0, -1, 1, 0, 1'b1, '0);
    add_frame(4000, 100, 200, 50, 1'b1, '0);
    // shrinking the settle count mid-capture ends it on the next frame
    add_cfg(CFG_SETTLE_COUNT, 24'd0);
    add_frame(1234, 300, 300, 60, 1'b1, '0);
    add_frame(4000, -32768, -32768, 70, 1'b1, peak);
    add_frame(8191, 1, 1, 1, 1'b0, '0);
    add_frame(0, 2, 3, 2, 1'b0, '0);
    // exactly half a turn either way is not a wrap
    add_frame(4096, 4, 5, 3, 1'b0, '0);
    add_frame(0, 6, 7, 4, 1'b0, '0);
    add_frame(4097, 8, 9, 5, 1'b0, '0);
    add_frame(0, 10, 11, 6, 1'b0, '0);
    add_frame(100, 32767, -32768, 7, 1'b0, '0);
    add_frame(200, 0, 32767, 8, 1'b0, '0);
    add_cfg(CFG_POWER_COEFF, 24'd0);
    add_frame(300, 5000, 5000, 9, 1'b0, '0);
    add_cfg(CFG_POWER_COEFF, POWER_COEFF_RST);
    add_cfg(CFG_SETTLE_COUNT, 24'd255);
    add_frame(400, 1000, 2000, 255, 1'b0, '0);
    add_frame(8000, -1, -1, 0, 1'b0, '0);

    foreach (steps[k]) begin
      if (steps[k].is_cfg) begin
        set_reg(steps[k].reg_idx, steps[k].reg_val);
      end else begin
        send_frame(steps[k].frame, steps[k].fixed, steps[k].res);
        if ($urandom_range(0, 2) == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
    end

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_reg(CFG_POWER_COEFF, CFG_W'($urandom_range(0, 24'hffffff)));
        1: set_reg(CFG_POWER_COEFF, 24'hffffff);
        2: set_reg(CFG_POWER_COEFF, 24'd1);
        3: begin
          set_reg(CFG_POWER_COEFF, CFG_W'($urandom_range(0, 24'hffffff)));
          set_reg(CFG_SETTLE_COUNT, CFG_W'($urandom_range(0, 255)));
        end
        default: set_reg(CFG_POWER_COEFF, POWER_COEFF_RST);
      endcase
      spin_down = ph[0];
      // long receiver hold-off while frames keep coming, to back up the queue
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        gap   = (ph == 1) ? 0 : $urandom_range(0, 8);
        repeat (burst) begin
          // mostly steady rotation with occasional near-half-turn and wild jumps
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
              step = $urandom_range(0, 600);
              if ($urandom_range(0, 4) == 0) step = -step;
            end
            6, 7: begin
              step = $urandom_range(4094, 4098);
              if ($urandom_range(0, 1) == 1) step = -step;
            end
            8: step = $urandom_range(0, 8191);
            default: step = 0;
          endcase
          if (spin_down) step = -step;
          f.angle = ANGLE_W'(int'(sent_angle) + step);
          if (step == 0) begin
            case ($urandom_range(0, 2))
              0: f.angle = '0;
              1: f.angle = '1;
              default: f.angle = 13'd4096;
            endcase
          end
          f.speed   = rand_s16();
          f.current = rand_s16();
          f.temp    = TEMP_W'($urandom_range(0, 255));
          send_frame(f, 1'b0, '0);
          sent++;
        end
        if (gap != 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
